FILE: hdl/cft_pkg.sv
// Shared types and constants for the cuckoo flow table.
package cft_pkg;

    localparam int HASH_W   = 18;   // protocol + two ports
    localparam int HASH_LAT = 4;    // S_HASH wait from key change to both slots ready
    localparam int KICK_W   = 8;
    localparam int COUNT_W  = 5;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_INSERTED = 3'd2,
        ST_PRESENT  = 3'd3,
        ST_UPDATED  = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } t_op;

    typedef struct packed {
        logic        valid;
        logic [63:0] addrs;
        logic [39:0] proto_ports;
        logic [63:0] value;
    } t_entry;

    typedef struct packed {
        logic    clr;
        logic    load;
        logic    rd;
        logic    upd;
        logic    place;
        logic    kick;
        logic    fin;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic op;
        logic hit_a;
        logic hit_b;
        logic val_eq;
        logic occ;
        logic kicks_max;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: hdl/cft_ctrl.sv
// Controller: clearing sweep, probe sequencing and eviction walk.
module cft_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  cft_pkg::t_dp_stat i_stat,
    output cft_pkg::t_dp_cmd  o_cmd
);
    import cft_pkg::*;

    typedef enum logic [3:0] {
        S_CLR  = 4'b0001,
        S_IDLE = 4'b0010,
        S_HASH = 4'b0100,
        S_CHK  = 4'b1000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_wait, n_wait;
    logic       r_first, n_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_wait  <= '0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
            r_first <= n_first;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_wait     = r_wait;
        n_first    = r_first;
        o_cmd      = '0;
        o_cmd.status = ST_MISS;
        o_in_stall = 1'b1;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_first    = 1'b1;
                    n_wait     = '0;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                n_wait = r_wait + 3'd1;
                if (r_wait == 3'(HASH_LAT)) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                if (r_first && i_stat.op == OP_LOOKUP) begin
                    if (i_stat.out_free) begin
                        o_cmd.fin    = 1'b1;
                        o_cmd.status = (i_stat.hit_a || i_stat.hit_b) ? ST_HIT : ST_MISS;
                        n_state      = S_IDLE;
                    end
                end else if (r_first && (i_stat.hit_a || i_stat.hit_b)) begin
                    if (i_stat.out_free) begin
                        o_cmd.fin    = 1'b1;
                        o_cmd.upd    = !i_stat.val_eq;
                        o_cmd.status = i_stat.val_eq ? ST_PRESENT : ST_UPDATED;
                        n_state      = S_IDLE;
                    end
                end else if (!i_stat.occ) begin
                    if (i_stat.out_free) begin
                        o_cmd.fin    = 1'b1;
                        o_cmd.place  = 1'b1;
                        o_cmd.status = ST_INSERTED;
                        n_state      = S_IDLE;
                    end
                end else if (i_stat.kicks_max) begin
                    if (i_stat.out_free) begin
                        o_cmd.fin    = 1'b1;
                        o_cmd.status = ST_OVERFLOW;
                        n_state      = S_IDLE;
                    end
                end else begin
                    // displace the occupant, then rehash it for the other table
                    o_cmd.kick = 1'b1;
                    n_first    = 1'b0;
                    n_wait     = '0;
                    n_state    = S_HASH;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

endmodule

FILE: hdl/cft_dp.sv
// Datapath: key in hand, slot hash pipeline, both tables and result register.
module cft_dp #(
    parameter int CAPACITY = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cft_pkg::t_dp_cmd  i_cmd,
    output cft_pkg::t_dp_stat o_stat,
    input  logic [7:0]        i_max_kicks,
    input  logic              i_opcode,
    input  logic [7:0]        i_protocol,
    input  logic [31:0]       i_src_addr,
    input  logic [31:0]       i_dst_addr,
    input  logic [15:0]       i_src_port_num,
    input  logic [15:0]       i_dst_port_num,
    input  logic [63:0]       i_new_value,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [63:0]       o_result_value,
    output logic [2:0]        o_status,
    output logic [4:0]        o_entry_count
);
    import cft_pkg::*;

    localparam int CW = $clog2(CAPACITY);
    localparam int HW = HASH_W;
    localparam int SH = HW + CW;
    localparam int MW = HW + 1;
    localparam int PW = HW + MW;
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << SH) / CAPACITY);
    localparam logic [HW-1:0] CAP_H = HW'(CAPACITY);
    localparam logic [CW-1:0] LAST  = CW'(CAPACITY - 1);

    // key in hand
    logic [63:0]        r_addrs;
    logic [39:0]        r_pp;
    logic [63:0]        r_value;
    logic               r_op;
    logic               r_tbl;
    logic [KICK_W-1:0]  r_kicks;
    logic [CW-1:0]      r_clr_addr;
    logic [COUNT_W-1:0] r_count, n_count;

    // hash pipeline
    logic [HW-1:0] h;
    logic [HW-1:0] r_h1, r_q1, r_q1d;
    logic [PW-1:0] r_p1, r_p2;
    logic [CW-1:0] r_r1, r_slot_b;
    logic [PW-1:0] sh1, sh2;
    logic [HW-1:0] q0a, q0b, rem_a, rem_b;
    logic [2*HW-1:0] qc_a, qc_b;
    logic          fix_a, fix_b;

    // tables
    t_entry mem_a [CAPACITY];
    t_entry mem_b [CAPACITY];
    t_entry r_rd_a, r_rd_b;
    t_entry wr_data, cur;
    logic   we_a, we_b;
    logic [CW-1:0] wa_a, wa_b;
    logic   hit_a, hit_b;

    logic               r_out_valid;
    logic [63:0]        r_out_value;
    t_status            r_out_status;
    logic [COUNT_W-1:0] r_out_count;

    assign h = HW'(r_pp[39:32]) + HW'(r_pp[31:16]) + HW'(r_pp[15:0]);

    // slot A = h mod CAP, slot B = (h div CAP) mod CAP, by reciprocal multiply
    assign sh1   = r_p1 >> SH;
    assign q0a   = sh1[HW-1:0];
    assign qc_a  = q0a * CAP_H;
    assign rem_a = r_h1 - qc_a[HW-1:0];
    assign fix_a = rem_a >= CAP_H;
    assign sh2   = r_p2 >> SH;
    assign q0b   = sh2[HW-1:0];
    assign qc_b  = q0b * CAP_H;
    assign rem_b = r_q1d - qc_b[HW-1:0];
    assign fix_b = rem_b >= CAP_H;

    always_ff @(posedge i_clk) begin
        r_h1  <= h;
        r_p1  <= PW'(h) * PW'(RECIP);
        r_q1  <= fix_a ? q0a + HW'(1) : q0a;
        r_r1  <= fix_a ? CW'(rem_a - CAP_H) : CW'(rem_a);
        r_q1d <= r_q1;
        r_p2  <= PW'(r_q1) * PW'(RECIP);
        r_slot_b <= fix_b ? CW'(rem_b - CAP_H) : CW'(rem_b);
    end

    assign hit_a = r_rd_a.valid && r_rd_a.addrs == r_addrs && r_rd_a.proto_ports == r_pp;
    assign hit_b = r_rd_b.valid && r_rd_b.addrs == r_addrs && r_rd_b.proto_ports == r_pp;
    assign cur   = r_tbl ? r_rd_b : r_rd_a;

    always_comb begin
        wr_data = i_cmd.clr ? t_entry'('0) : {1'b1, r_addrs, r_pp, r_value};
        wa_a    = i_cmd.clr ? r_clr_addr : r_r1;
        wa_b    = i_cmd.clr ? r_clr_addr : r_slot_b;
        we_a    = i_cmd.clr || (i_cmd.upd && hit_a)
               || ((i_cmd.place || i_cmd.kick) && !r_tbl);
        we_b    = i_cmd.clr || (i_cmd.upd && !hit_a)
               || ((i_cmd.place || i_cmd.kick) && r_tbl);
        n_count = i_cmd.place ? r_count + COUNT_W'(1) : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (we_a) mem_a[wa_a] <= wr_data;
        if (we_b) mem_b[wa_b] <= wr_data;
        if (i_cmd.rd) begin
            r_rd_a <= mem_a[r_r1];
            r_rd_b <= mem_b[r_slot_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addrs <= {i_src_addr, i_dst_addr};
            r_pp    <= {i_protocol, i_src_port_num, i_dst_port_num};
            r_value <= i_new_value;
            r_op    <= i_opcode;
        end else if (i_cmd.kick) begin
            r_addrs <= cur.addrs;
            r_pp    <= cur.proto_ports;
            r_value <= cur.value;
        end
        if (i_cmd.fin) begin
            r_out_value  <= (i_cmd.status == ST_HIT)
                          ? (hit_a ? r_rd_a.value : r_rd_b.value) : 64'd0;
            r_out_status <= i_cmd.status;
            r_out_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl       <= 1'b0;
            r_kicks     <= '0;
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_tbl   <= 1'b0;
                r_kicks <= '0;
            end else if (i_cmd.kick) begin
                r_tbl   <= !r_tbl;
                r_kicks <= r_kicks + KICK_W'(1);
            end
            if (i_cmd.clr) r_clr_addr <= r_clr_addr + CW'(1);
            r_count <= n_count;
            if (i_cmd.fin) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_stat.clr_last  = r_clr_addr == LAST;
        o_stat.op        = r_op;
        o_stat.hit_a     = hit_a;
        o_stat.hit_b     = hit_b;
        o_stat.val_eq    = (hit_a ? r_rd_a.value : r_rd_b.value) == r_value;
        o_stat.occ       = cur.valid;
        o_stat.kicks_max = r_kicks >= i_max_kicks;
        o_stat.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_entry_count  = r_out_count;

endmodule

FILE: hdl/cuckoo_flow_table_unit.sv
// Top level of the two-way cuckoo flow table.
// Two tables of CAPACITY entries, slot A = h mod CAPACITY and slot B =
// (h div CAPACITY) mod CAPACITY with h = protocol + src port + dst port. After
// reset a clearing pass writes every entry of both tables before the first
// transaction is taken. A lookup or a hit on insert passes the slot hash
// pipeline, one registered table read, and one decision step that loads the
// result register once the output is free. Each eviction reruns the hash and
// the table read for the displaced entry, up to max_kicks displacements. The
// controller returns to idle before taking the next transaction, and one
// transaction is in work at a time; a finished result waits in its own
// register while the next transaction is accepted.
module cuckoo_flow_table_unit #(
    parameter int CAPACITY = 11
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_protocol,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_src_port_num,
    input  logic [15:0] i_dst_port_num,
    input  logic [63:0] i_new_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_result_value,
    output logic [2:0]  o_status,
    output logic [4:0]  o_entry_count
);
    import cft_pkg::*;

    logic [7:0] r_max_kicks;
    t_dp_cmd    cmd;
    t_dp_stat   stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_kicks <= 8'd32;
        end else if (i_cfg_we) begin
            r_max_kicks <= i_cfg_wdata;
        end
    end

    cft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cft_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_max_kicks    (r_max_kicks),
        .i_opcode       (i_opcode),
        .i_protocol     (i_protocol),
        .i_src_addr     (i_src_addr),
        .i_dst_addr     (i_dst_addr),
        .i_src_port_num (i_src_port_num),
        .i_dst_port_num (i_dst_port_num),
        .i_new_value    (i_new_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count)
    );

`ifndef SYNTH
    // one transaction in work at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a transaction is in work");

    // only a lookup hit carries a value
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_HIT) |-> o_result_value == 64'd0)
        else $error("non-hit result with nonzero value");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_HIT || o_status == ST_MISS
            || o_status == ST_INSERTED || o_status == ST_PRESENT
            || o_status == ST_UPDATED || o_status == ST_OVERFLOW))
        else $error("undefined status code");
`endif

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the cuckoo flow table unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cft_pkg::*;

    localparam int CAP = 11;
    localparam int CYCLE_LIMIT = 20000000;

    typedef struct {
        logic [63:0] value;
        t_status     status;
        logic [4:0]  count;
    } t_flow_result;

    // Flow table shadow: predicts each result and queues it until the block answers.
    class flow_scoreboard;
        logic [7:0]   kick_limit;
        logic         va[CAP];
        logic         vb[CAP];
        logic [63:0]  aa[CAP];
        logic [63:0]  ab[CAP];
        logic [39:0]  pa[CAP];
        logic [39:0]  pb[CAP];
        logic [63:0]  wa[CAP];
        logic [63:0]  wb[CAP];
        t_flow_result pending[$];
        int           mismatches;

        function void clear();
            kick_limit = 8'd32;
            for (int i = 0; i < CAP; i++) begin
                va[i] = 1'b0;
                vb[i] = 1'b0;
            end
            pending.delete();
            mismatches = 0;
        endfunction

        function int slot(bit tbl_b, logic [39:0] pp);
            int h;
            h = pp[39:32] + pp[31:16] + pp[15:0];
            return tbl_b ? (h / CAP) % CAP : h % CAP;
        endfunction

        function logic [4:0] occupancy();
            int n;
            n = 0;
            for (int i = 0; i < CAP; i++) n += va[i] + vb[i];
            return n[4:0];
        endfunction

        function t_status place(logic [63:0] ad, logic [39:0] pp, logic [63:0] val);
            bit          tb;
            int          kicks;
            int          i;
            logic [63:0] tad;
            logic [39:0] tpp;
            logic [63:0] tval;
            tb = 0;
            kicks = 0;
            forever begin
                i = slot(tb, pp);
                if (!tb && !va[i]) begin
                    va[i] = 1; aa[i] = ad; pa[i] = pp; wa[i] = val;
                    return ST_INSERTED;
                end
                if (tb && !vb[i]) begin
                    vb[i] = 1; ab[i] = ad; pb[i] = pp; wb[i] = val;
                    return ST_INSERTED;
                end
                if (kicks >= kick_limit) return ST_OVERFLOW;
                if (!tb) begin
                    tad = aa[i]; tpp = pa[i]; tval = wa[i];
                    aa[i] = ad; pa[i] = pp; wa[i] = val;
                end else begin
                    tad = ab[i]; tpp = pb[i]; tval = wb[i];
                    ab[i] = ad; pb[i] = pp; wb[i] = val;
                end
                ad = tad; pp = tpp; val = tval;
                kicks++;
                tb = !tb;
            end
        endfunction

        function void note_request(t_op op, logic [63:0] ad, logic [39:0] pp, logic [63:0] nv);
            t_flow_result r;
            int           ia;
            int           ib;
            bit           in_a;
            bit           in_b;
            ia = slot(0, pp);
            ib = slot(1, pp);
            in_a = va[ia] && aa[ia] == ad && pa[ia] == pp;
            in_b = !in_a && vb[ib] && ab[ib] == ad && pb[ib] == pp;
            r.value = '0;
            if (op == OP_LOOKUP) begin
                if (in_a) begin
                    r.value = wa[ia]; r.status = ST_HIT;
                end else if (in_b) begin
                    r.value = wb[ib]; r.status = ST_HIT;
                end else begin
                    r.status = ST_MISS;
                end
            end else if (in_a) begin
                r.status = (wa[ia] == nv) ? ST_PRESENT : ST_UPDATED;
                wa[ia] = nv;
            end else if (in_b) begin
                r.status = (wb[ib] == nv) ? ST_PRESENT : ST_UPDATED;
                wb[ib] = nv;
            end else begin
                r.status = place(ad, pp, nv);
            end
            r.count = occupancy();
            pending.push_back(r);
        endfunction

        function void check_result(logic [63:0] value, logic [2:0] status, logic [4:0] count);
            t_flow_result e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: value %h status %0d count %0d",
                                               value, status, count);
                return;
            end
            e = pending.pop_front();
            if (value !== e.value || status !== e.status || count !== e.count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp value %h status %0d count %0d, got %h %0d %0d",
                             e.value, e.status, e.count, value, status, count);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_opcode;
    logic [7:0]  i_protocol;
    logic [31:0] i_src_addr;
    logic [31:0] i_dst_addr;
    logic [15:0] i_src_port_num;
    logic [15:0] i_dst_port_num;
    logic [63:0] i_new_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [63:0] o_result_value;
    logic [2:0]  o_status;
    logic [4:0]  o_entry_count;

    cuckoo_flow_table_unit #(.CAPACITY(CAP)) i_dut (.*);

    flow_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles;
    int  cycle_count;
    // small pool of keys so inserts collide, evict and revisit known flows
    logic [63:0] pool_addrs[16];
    logic [39:0] pool_pp[16];
    logic [63:0] pool_val[16];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout");
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stall, or a forced long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_result_value, o_status, o_entry_count);
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                hold_cycles <= hold_cycles - 1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    task automatic write_kicks(input logic [7:0] k);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= k;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.kick_limit = k;
    endtask

    task automatic send_flow(input t_op op, input logic [63:0] ad, input logic [39:0] pp,
                             input logic [63:0] nv);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_src_addr <= ad[63:32];
        i_dst_addr <= ad[31:0];
        i_protocol <= pp[39:32];
        i_src_port_num <= pp[31:16];
        i_dst_port_num <= pp[15:0];
        i_new_value <= nv;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(op, ad, pp, nv);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8 + 6 * 256) @(posedge i_clk);
    endtask

    task automatic fresh_pool();
        for (int i = 0; i < 16; i++) begin
            pool_addrs[i] = {$urandom, $urandom};
            // ports kept small so hashes pile onto few slots
            pool_pp[i] = {8'($urandom_range(3)), 16'($urandom_range(40)), 16'($urandom_range(40))};
            if ($urandom_range(9) == 0) pool_pp[i] = {$urandom, 8'($urandom)};
            pool_val[i] = {$urandom, $urandom};
        end
    endtask

    task automatic random_flows(input int n);
        int          k;
        logic [63:0] ad;
        logic [39:0] pp;
        logic [63:0] nv;
        t_op         op;
        for (int j = 0; j < n; j++) begin
            k = $urandom_range(15);
            ad = pool_addrs[k];
            pp = pool_pp[k];
            nv = ($urandom_range(2) == 0) ? {$urandom, $urandom} : pool_val[k];
            op = t_op'($urandom_range(1));
            case ($urandom_range(9))
                0: ad = {$urandom, $urandom};
                1: pp = {$urandom, 8'($urandom)};
                2: ad[$urandom_range(63)] ^= 1'b1;
                default: ;
            endcase
            send_flow(op, ad, pp, nv);
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        cycle_count = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_opcode = OP_LOOKUP;
        i_protocol = '0;
        i_src_addr = '0;
        i_dst_addr = '0;
        i_src_port_num = '0;
        i_dst_port_num = '0;
        i_new_value = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: miss on empty, insert, present, update, hit, extremes
        send_flow(OP_LOOKUP, '0, '0, '0);
        send_flow(OP_INSERT, '0, '0, '1);
        send_flow(OP_INSERT, '0, '0, '1);
        send_flow(OP_INSERT, '0, '0, 64'h5);
        send_flow(OP_LOOKUP, '0, '0, '0);
        send_flow(OP_INSERT, '1, '1, '1);
        send_flow(OP_LOOKUP, '1, '1, '0);
        send_flow(OP_LOOKUP, 64'h1, '0, '0);
        // same hash bucket forces evictions (hash 11*k stays in slot 0 of table A)
        for (int i = 0; i < 6; i++)
            send_flow(OP_INSERT, 64'(i), {8'd0, 16'(11 * i), 16'd0}, 64'(i + 100));
        for (int i = 0; i < 6; i++)
            send_flow(OP_LOOKUP, 64'(i), {8'd0, 16'(11 * i), 16'd0}, '0);
        drain();

        // kick limit of one, then all keys on one hash -> overflow
        write_kicks(8'd1);
        for (int i = 0; i < 4; i++)
            send_flow(OP_INSERT, 64'(i + 50), {8'd0, 16'd0, 16'd7}, 64'(i));
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            case (ph)
                0: write_kicks(8'd255);
                1: write_kicks(8'd0);
                2: write_kicks(8'd2);
                3: write_kicks(8'($urandom_range(1, 255)));
                5: write_kicks(8'd32);
                default: write_kicks(8'($urandom_range(1, 8)));
            endcase
            fresh_pool();
            if (ph == 4) hold_cycles = 400;
            random_flows(180);
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
